/* rtl/nts_pkg.sv */
// Shared types, constants and the sRGB decode table for the texel sampler.
`default_nettype none

package nts_pkg;

    localparam int TEX_DIM_DEFAULT = 256;
    localparam int STORE_AW = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int TEXEL_W = 24;
    localparam int SIZE_W = 9;
    localparam int CFG_IDX_W = 4;
    localparam int FRAC_W = 16;
    localparam int LIN_W = 16;
    localparam int BIG_W = 320;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [15:0]       texel_address;
        logic [7:0]        write_red;
        logic [7:0]        write_green;
        logic [7:0]        write_blue;
        logic signed [23:0] coord_u;
        logic signed [23:0] coord_v;
    } in_item_t;

    typedef struct packed {
        logic [LIN_W-1:0] linear_red;
        logic [LIN_W-1:0] linear_green;
        logic [LIN_W-1:0] linear_blue;
    } out_item_t;

    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [STORE_AW-1:0] addr;
        logic [TEXEL_W-1:0]  wdata;
    } store_req_t;

    typedef logic [255:0][LIN_W-1:0] lut_t;

    // Linear value of one sRGB byte in Q0.16, rounded to nearest and saturated.
    // The power branch finds the largest T with T^5 * 269025^12 <= N^12 * 2^85,
    // which is floor(y * 2^17) for y = (N / 269025)^2.4, using exact integers.
    function automatic logic [LIN_W-1:0] decode_entry(input logic [7:0] c);
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        logic [31:0]      n;
        logic [31:0]      lo;
        logic [31:0]      hi;
        logic [31:0]      mid;
        logic [31:0]      r;
        int               k;
        int               step;
        n = 32'(c);
        if (n <= 32'd10)
        begin
            r = (32'd1310720 * n + 32'd32946) / 32'd65892;
            return LIN_W'(r);
        end
        n = 32'd1000 * n + 32'd14025;
        rhs = BIG_W'(1);
        for (k = 0; k < 12; k++)
        begin
            rhs = rhs * BIG_W'(n);
        end
        rhs = rhs << 85;
        lo = 32'd0;
        hi = 32'd131072;
        for (step = 0; step < 18; step++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 32'd1) >> 1;
                lhs = BIG_W'(1);
                for (k = 0; k < 5; k++)
                begin
                    lhs = lhs * BIG_W'(mid);
                end
                for (k = 0; k < 12; k++)
                begin
                    lhs = lhs * BIG_W'(269025);
                end
                if (lhs <= rhs)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 32'd1;
                end
            end
        end
        r = (lo + 32'd1) >> 1;
        return (r > 32'd65535) ? 16'hFFFF : LIN_W'(r);
    endfunction

    function automatic lut_t build_decode_lut();
        lut_t lut;
        int   i;
        for (i = 0; i < 256; i++)
        begin
            lut[i] = decode_entry(8'(i));
        end
        return lut;
    endfunction

    localparam lut_t DECODE_LUT = build_decode_lut();

endpackage

`default_nettype wire

/* rtl/nts_store.sv */
// Single-port texel RAM with a registered read port.
`default_nettype none

module nts_store (
    input  wire logic                      clk,
    input  wire nts_pkg::store_req_t       req,
    output logic [nts_pkg::TEXEL_W-1:0]    rdata
);

    logic [nts_pkg::TEXEL_W-1:0] mem [nts_pkg::STORE_DEPTH];
    logic [nts_pkg::TEXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/nearest_texel_sampler_srgb.sv */
// Top level: pipelined nearest-texel sampler with repeat wrap and sRGB decode.
// A sample item is accepted, scaled, addressed, read and decoded over four register
// stages: stage 1, stage 2, texel read and output registers. One item per cycle is
// sustained unless stalled; the single-port texel RAM serves either the write of a
// write item or the read of a sample item in each cycle. Write items give no result.
// Reset clears the valid bits and sets both size registers to 1; texels are not cleared.
`default_nettype none

module nearest_texel_sampler_srgb #(
    parameter int TEX_DIM = nts_pkg::TEX_DIM_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire nts_pkg::in_item_t               in_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output nts_pkg::out_item_t                   out_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [nts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nts_pkg::SIZE_W-1:0]      cfg_data
);

    localparam int DIM_W = $clog2(TEX_DIM + 1);
    localparam int CMP_W = (DIM_W > nts_pkg::SIZE_W) ? DIM_W : nts_pkg::SIZE_W;
    localparam int ROW_W = 2 * DIM_W;
    localparam int SUM_W = (ROW_W + 1 > nts_pkg::STORE_AW) ? ROW_W + 1 : nts_pkg::STORE_AW;
    localparam int PU_W = nts_pkg::FRAC_W + DIM_W;
    localparam int PV_W = nts_pkg::FRAC_W + 1 + DIM_W;
    localparam logic [CMP_W-1:0] DIM_C = CMP_W'(TEX_DIM);

    // Size registers
    logic [nts_pkg::SIZE_W-1:0] width_reg;
    logic [nts_pkg::SIZE_W-1:0] height_reg;
    logic [CMP_W-1:0]           w_ext;
    logic [CMP_W-1:0]           h_ext;
    logic [DIM_W-1:0]           eff_w;
    logic [DIM_W-1:0]           eff_h;
    logic [DIM_W-1:0]           w_max;
    logic [DIM_W-1:0]           h_max;

    // Pipeline control
    logic can1;
    logic can2;
    logic can3;
    logic can4;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic out_valid_reg;

    // Stage 1: scaled coordinates
    logic                           op1_reg;
    logic [nts_pkg::STORE_AW-1:0]   waddr1_reg;
    logic [nts_pkg::TEXEL_W-1:0]    wdata1_reg;
    logic [DIM_W-1:0]               x1_reg;
    logic [DIM_W:0]                 y1_reg;
    logic [PU_W-1:0]                prod_u;
    logic [PV_W-1:0]                prod_v;
    logic [nts_pkg::FRAC_W:0]       fv_inv;

    // Stage 2: row base and column
    logic                           op2_reg;
    logic [nts_pkg::STORE_AW-1:0]   waddr2_reg;
    logic [nts_pkg::TEXEL_W-1:0]    wdata2_reg;
    logic [ROW_W-1:0]               row2_reg;
    logic [DIM_W-1:0]               x2_reg;
    logic [DIM_W-1:0]               x_clamp;
    logic [DIM_W-1:0]               y_clamp;
    logic [ROW_W-1:0]               row_next;
    logic [SUM_W-1:0]               addr_sum;

    // Stage 3: texel read, stage 4: decoded result
    nts_pkg::store_req_t            store_req;
    logic [nts_pkg::TEXEL_W-1:0]    texel;
    nts_pkg::out_item_t             out_item_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= nts_pkg::SIZE_W'(1);
            height_reg <= nts_pkg::SIZE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nts_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                nts_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A size of zero acts as one, and sizes above the maximum are clamped to it.
    always_comb
    begin
        w_ext = CMP_W'(width_reg);
        h_ext = CMP_W'(height_reg);
        if (w_ext == '0)
            eff_w = DIM_W'(1);
        else if (w_ext > DIM_C)
            eff_w = DIM_W'(TEX_DIM);
        else
            eff_w = DIM_W'(w_ext);
        if (h_ext == '0)
            eff_h = DIM_W'(1);
        else if (h_ext > DIM_C)
            eff_h = DIM_W'(TEX_DIM);
        else
            eff_h = DIM_W'(h_ext);
        w_max = eff_w - DIM_W'(1);
        h_max = eff_h - DIM_W'(1);
    end

    // A write item leaves stage 2 through the RAM write port and never waits on stage 3.
    assign can4 = !out_valid_reg || !out_stall;
    assign can3 = !v3_reg || can4;
    assign can2 = !v2_reg || (op2_reg == nts_pkg::OP_WRITE) || can3;
    assign can1 = !v1_reg || can2;
    assign in_stall = !can1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (can1)
                v1_reg <= in_valid;
            if (can2)
                v2_reg <= v1_reg;
            if (can3)
                v3_reg <= v2_reg && (op2_reg == nts_pkg::OP_SAMPLE);
            if (can4)
                out_valid_reg <= v3_reg;
        end
    end

    // The fraction of a signed Q7.16 coordinate is its low 16 bits; v is flipped.
    always_comb
    begin
        fv_inv = (nts_pkg::FRAC_W + 1)'(1 << nts_pkg::FRAC_W)
               - {1'b0, in_item.coord_v[nts_pkg::FRAC_W-1:0]};
        prod_u = PU_W'(in_item.coord_u[nts_pkg::FRAC_W-1:0]) * PU_W'(eff_w);
        prod_v = PV_W'(fv_inv) * PV_W'(eff_h);
    end

    always_ff @(posedge clk)
    begin
        if (can1)
        begin
            op1_reg    <= in_item.opcode;
            waddr1_reg <= in_item.texel_address;
            wdata1_reg <= {in_item.write_red, in_item.write_green, in_item.write_blue};
            x1_reg     <= prod_u[nts_pkg::FRAC_W +: DIM_W];
            y1_reg     <= prod_v[nts_pkg::FRAC_W +: DIM_W + 1];
        end
    end

    // A zero v fraction lands one row past the end and is pulled back to the last row.
    always_comb
    begin
        x_clamp  = (x1_reg > w_max) ? w_max : x1_reg;
        y_clamp  = (y1_reg > {1'b0, h_max}) ? h_max : y1_reg[DIM_W-1:0];
        row_next = ROW_W'(y_clamp) * ROW_W'(eff_w);
    end

    always_ff @(posedge clk)
    begin
        if (can2)
        begin
            op2_reg    <= op1_reg;
            waddr2_reg <= waddr1_reg;
            wdata2_reg <= wdata1_reg;
            row2_reg   <= row_next;
            x2_reg     <= x_clamp;
        end
    end

    always_comb
    begin
        addr_sum        = SUM_W'(row2_reg) + SUM_W'(x2_reg);
        store_req.wr_en = v2_reg && (op2_reg == nts_pkg::OP_WRITE);
        store_req.rd_en = v2_reg && (op2_reg == nts_pkg::OP_SAMPLE) && can3;
        store_req.addr  = (op2_reg == nts_pkg::OP_WRITE) ? waddr2_reg
                                                          : addr_sum[nts_pkg::STORE_AW-1:0];
        store_req.wdata = wdata2_reg;
    end

    nts_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (texel)
    );

    always_ff @(posedge clk)
    begin
        if (can4 && v3_reg)
        begin
            out_item_reg.linear_red   <= nts_pkg::DECODE_LUT[texel[23:16]];
            out_item_reg.linear_green <= nts_pkg::DECODE_LUT[texel[15:8]];
            out_item_reg.linear_blue  <= nts_pkg::DECODE_LUT[texel[7:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

/* rtl/nts_checker.sv */
// Port-level checks of the texel sampler, bound to the top level.
`default_nettype none

module nts_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire nts_pkg::in_item_t  in_item,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire nts_pkg::out_item_t out_item
);

    // A result held by the consumer stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("held result changed");

    // With the output register empty every stage can advance.
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty output register");

    // A sample item accepted at the input passes the stage 1, stage 2, texel read
    // and output registers and is seen on the output when the consumer keeps taking.
    a_sample_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_item.opcode == nts_pkg::OP_SAMPLE))
        ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("sample result missing after pipeline latency");

endmodule

bind nearest_texel_sampler_srgb nts_checker u_nts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
